@@ src/i2cmbe_pkg.sv @@
package i2cmbe_pkg;

  localparam int unsigned TicksW     = 16;
  localparam int unsigned PhaseW     = 4;
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned BitCntW    = $clog2(ByteBits);
  localparam int unsigned QueueDepth = 4;
  localparam logic [TicksW-1:0] TicksReset = TicksW'(6);

  typedef enum logic [2:0] {
    CmdIdle  = 3'd0,
    CmdStart = 3'd1,
    CmdStop  = 3'd2,
    CmdSend  = 3'd3,
    CmdRecv  = 3'd4,
    CmdAck   = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_released;
    logic       busy_res;
    logic       done_res;
    logic       ack_received;
    logic [7:0] rx_byte;
  } out_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_in;
  } item_t;

endpackage

@@ src/i2cmbe_front.sv @@
module i2cmbe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  i2cmbe_pkg::in_t    in_data_i,
  output logic               push_o,
  input  logic               full_i,
  output i2cmbe_pkg::item_t  item_o
);

  logic              valid_q;
  i2cmbe_pkg::item_t item_q;
  i2cmbe_pkg::item_t item_d;
  logic              take;

  always_comb begin
    item_d.tx_byte   = in_data_i.tx_byte;
    item_d.ack_level = in_data_i.ack_level;
    item_d.sda_in    = in_data_i.sda_in;
    if (in_data_i.action >= 3'(i2cmbe_pkg::CmdStart) &&
        in_data_i.action <= 3'(i2cmbe_pkg::CmdAck)) begin
      item_d.cmd = i2cmbe_pkg::cmd_e'(in_data_i.action);
    end else begin
      item_d.cmd = i2cmbe_pkg::CmdIdle;
    end
  end

  assign push_o     = valid_q && !full_i;
  assign in_stall_o = valid_q && full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

@@ src/i2cmbe_queue.sv @@
module i2cmbe_queue #(
  parameter int unsigned Depth = i2cmbe_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  i2cmbe_pkg::item_t  push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output i2cmbe_pkg::item_t  pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  i2cmbe_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ src/i2cmbe_back.sv @@
module i2cmbe_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [i2cmbe_pkg::TicksW-1:0]    phase_ticks_i,
  input  logic                             valid_i,
  input  i2cmbe_pkg::item_t                item_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output i2cmbe_pkg::out_t                 out_data_o
);

  localparam int unsigned TicksW  = i2cmbe_pkg::TicksW;
  localparam int unsigned PhaseW  = i2cmbe_pkg::PhaseW;
  localparam int unsigned BitCntW = i2cmbe_pkg::BitCntW;
  localparam logic [BitCntW-1:0] LastBit = BitCntW'(i2cmbe_pkg::ByteBits - 1);

  i2cmbe_pkg::cmd_e   cmd_q, cmd_d, ecmd;
  logic [PhaseW-1:0]  phase_q, phase_d, eph;
  logic [BitCntW-1:0] bit_q, bit_d, ebit;
  logic [TicksW-1:0]  wait_q, wait_d, load_val;
  logic [7:0]         shift_q, shift_d, esh;
  logic [7:0]         rx_q, rx_d;
  logic               scl_q, scl_d;
  logic               sda_q, sda_d;
  logic               rel_q, rel_d;
  logic               ack_q, ack_d;
  logic               do_enter, seg_ok, done;
  logic               out_valid_q;
  i2cmbe_pkg::out_t   out_q, out_d;

  assign pop_o       = valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign load_val    = (phase_ticks_i == '0) ? TicksW'(1) : phase_ticks_i;

  always_comb begin
    cmd_d    = cmd_q;
    phase_d  = phase_q;
    bit_d    = bit_q;
    wait_d   = wait_q;
    shift_d  = shift_q;
    rx_d     = rx_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    rel_d    = rel_q;
    ack_d    = ack_q;
    ecmd     = cmd_q;
    eph      = phase_q;
    ebit     = bit_q;
    esh      = shift_q;
    do_enter = 1'b0;
    seg_ok   = 1'b1;
    done     = 1'b0;

    if (cmd_q == i2cmbe_pkg::CmdIdle) begin
      if (item_i.cmd != i2cmbe_pkg::CmdIdle) begin
        ecmd     = item_i.cmd;
        eph      = '0;
        ebit     = '0;
        do_enter = 1'b1;
        if (item_i.cmd == i2cmbe_pkg::CmdSend) begin
          esh = item_i.tx_byte;
        end else if (item_i.cmd == i2cmbe_pkg::CmdRecv) begin
          esh = '0;
        end
        if (item_i.cmd == i2cmbe_pkg::CmdAck) begin
          sda_d = item_i.ack_level;
        end
      end
    end else begin
      wait_d = (wait_q != '0) ? wait_q - TicksW'(1) : wait_q;
      if (wait_d == '0) begin
        do_enter = 1'b1;
        if ((cmd_q == i2cmbe_pkg::CmdSend || cmd_q == i2cmbe_pkg::CmdRecv) &&
            phase_q == PhaseW'(1) && bit_q != LastBit) begin
          ebit = bit_q + BitCntW'(1);
          eph  = '0;
        end else begin
          eph = phase_q + PhaseW'(1);
        end
      end
    end

    if (do_enter) begin
      cmd_d   = ecmd;
      phase_d = eph;
      bit_d   = ebit;
      shift_d = esh;
      unique case (ecmd)
        i2cmbe_pkg::CmdStart: begin
          case (eph)
            PhaseW'(0): sda_d = 1'b1;
            PhaseW'(1): scl_d = 1'b1;
            PhaseW'(2): sda_d = 1'b0;
            PhaseW'(3): scl_d = 1'b0;
            default:    seg_ok = 1'b0;
          endcase
        end
        i2cmbe_pkg::CmdStop: begin
          case (eph)
            PhaseW'(0): sda_d = 1'b0;
            PhaseW'(1): scl_d = 1'b1;
            PhaseW'(2): sda_d = 1'b1;
            default:    seg_ok = 1'b0;
          endcase
        end
        i2cmbe_pkg::CmdAck: begin
          case (eph)
            PhaseW'(0): seg_ok = 1'b1;
            PhaseW'(1): scl_d = 1'b1;
            PhaseW'(2): scl_d = 1'b0;
            default:    seg_ok = 1'b0;
          endcase
        end
        i2cmbe_pkg::CmdSend: begin
          case (eph)
            PhaseW'(0): begin
              if (ebit != '0) begin
                scl_d = 1'b0;
              end
              sda_d   = esh[7];
              shift_d = {esh[6:0], 1'b0};
            end
            PhaseW'(1): scl_d = 1'b1;
            PhaseW'(2): begin
              scl_d = 1'b0;
              rel_d = 1'b1;
            end
            PhaseW'(3): scl_d = 1'b1;
            PhaseW'(4): begin
              ack_d = !item_i.sda_in;
              scl_d = 1'b0;
            end
            default: begin
              rel_d  = 1'b0;
              seg_ok = 1'b0;
            end
          endcase
        end
        i2cmbe_pkg::CmdRecv: begin
          case (eph)
            PhaseW'(0): begin
              if (ebit == '0) begin
                rel_d = 1'b1;
              end
              scl_d = 1'b1;
            end
            PhaseW'(1): begin
              shift_d = {esh[6:0], item_i.sda_in};
              scl_d   = 1'b0;
            end
            default: begin
              rel_d  = 1'b0;
              rx_d   = esh;
              seg_ok = 1'b0;
            end
          endcase
        end
        default: seg_ok = 1'b0;
      endcase
      if (seg_ok) begin
        wait_d = load_val;
      end else begin
        cmd_d   = i2cmbe_pkg::CmdIdle;
        phase_d = '0;
        bit_d   = '0;
        done    = 1'b1;
      end
    end

    out_d.scl_level    = scl_d;
    out_d.sda_level    = sda_d;
    out_d.sda_released = rel_d;
    out_d.busy_res     = (cmd_d != i2cmbe_pkg::CmdIdle);
    out_d.done_res     = done;
    out_d.ack_received = ack_d;
    out_d.rx_byte      = rx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= i2cmbe_pkg::CmdIdle;
      phase_q     <= '0;
      bit_q       <= '0;
      wait_q      <= '0;
      shift_q     <= '0;
      rx_q        <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      rel_q       <= 1'b0;
      ack_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cmd_q   <= cmd_d;
        phase_q <= phase_d;
        bit_q   <= bit_d;
        wait_q  <= wait_d;
        shift_q <= shift_d;
        rx_q    <= rx_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        rel_q   <= rel_d;
        ack_q   <= ack_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

endmodule

@@ src/i2c_master_bit_engine.sv @@
// I2C master bit engine. Every request is one time tick and yields exactly one result carrying
// the SCL and SDA levels, SDA direction, busy, done, the ack flag and the last received byte.
// A tick may carry a command, which is taken only while no command is running. The block accepts
// one request per clock cycle and returns one result per cycle while neither side stalls; each
// result passes through the input register, the request queue and the output register, and the
// queue absorbs short output stalls. phase_ticks may be written only while no request is in
// flight.
module i2c_master_bit_engine #(
  parameter int unsigned QueueDepth = i2cmbe_pkg::QueueDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  i2cmbe_pkg::in_t                in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output i2cmbe_pkg::out_t               out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [i2cmbe_pkg::TicksW-1:0]  cfg_data_i
);

  logic [i2cmbe_pkg::TicksW-1:0] phase_ticks_q;
  logic                          push;
  logic                          full;
  logic                          pop;
  logic                          q_valid;
  i2cmbe_pkg::item_t             front_item;
  i2cmbe_pkg::item_t             back_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= i2cmbe_pkg::TicksReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      phase_ticks_q <= cfg_data_i;
    end
  end

  i2cmbe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .full_i     (full),
    .item_o     (front_item)
  );

  i2cmbe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (back_item)
  );

  i2cmbe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .phase_ticks_i (phase_ticks_q),
    .valid_i       (q_valid),
    .item_i        (back_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule
